FILE: rtl/core/isrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared types and constants for the insertion sorter core.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/isrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the sorted run: compare-and-shift on insert, shift down on drain.
// ----------------------------------------------------------------------------
module isrt_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  isrt_pkg::cell_ctrl_t                ctrl,
  input  logic signed [isrt_pkg::VALUE_W-1:0] ins_value,
  input  logic signed [isrt_pkg::VALUE_W-1:0] left_value,
  input  logic                                left_valid,
  input  logic                                left_gt,
  input  logic signed [isrt_pkg::VALUE_W-1:0] right_value,
  input  logic                                right_valid,
  output logic signed [isrt_pkg::VALUE_W-1:0] value,
  output logic                                valid,
  output logic                                gt
);

  // entry strictly greater than the incoming value moves up
  assign gt = valid && (value > ins_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt || (!valid && left_valid)) begin
        value <= ins_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      valid <= valid || left_valid;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end
  end

endmodule

FILE: rtl/core/insertion_sorter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Streaming insertion sort of signed 32-bit values in a chain of cells.
// ----------------------------------------------------------------------------
// The slave channel takes one signed value per transfer; tlast closes a set.
// Each value is placed into a chain of DEPTH cells in the transfer's cycle,
// so values enter at one per cycle while a set is being collected.
// Values beyond DEPTH in one set are dropped and flag the set as overflowed.
// After the transfer carrying tlast the core stops taking input and drains
// the run in ascending order on the master channel, one transfer per cycle,
// the first result in the cycle after the closing input transfer. tlast marks
// the largest value, tuser carries the overflow flag on every result.
// The drain shifts the whole chain one cell towards the output per transfer.
// While the receiver holds tready low the current result stays on the port
// and the chain holds. Input is taken again in the cycle after the final
// result transfer. Reset empties the chain, clears the overflow flag and
// returns to collecting; stored values need no clearing.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
  parameter int DEPTH = isrt_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_res[31:0]
  output logic        m_tlast,
  output logic        m_tuser    // overflow
);

  isrt_pkg::state_t     state;
  isrt_pkg::state_t     state_next;
  isrt_pkg::cell_ctrl_t ctrl;
  logic                 dropped;
  logic                 dropped_next;
  logic                 full;
  logic                 in_xfer;
  logic                 out_xfer;

  logic signed [isrt_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]                    cell_valid;
  logic [DEPTH-1:0]                    cell_gt;
  logic signed [isrt_pkg::VALUE_W-1:0] ins_value;

  assign ins_value = s_tdata;
  assign full      = cell_valid[DEPTH-1];
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;

  assign s_tready = (state == isrt_pkg::ST_FILL);
  assign m_tvalid = (state == isrt_pkg::ST_DRAIN);
  assign m_tdata  = cell_value[0];
  assign m_tlast  = !cell_valid[1];
  assign m_tuser  = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= isrt_pkg::ST_FILL;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    ctrl.insert  = 1'b0;
    ctrl.shift   = 1'b0;
    case (state)
      isrt_pkg::ST_FILL: begin
        if (in_xfer) begin
          ctrl.insert = !full;
          if (full) begin
            dropped_next = 1'b1;
          end
          if (s_tlast) begin
            state_next = isrt_pkg::ST_DRAIN;
          end
        end
      end
      isrt_pkg::ST_DRAIN: begin
        if (out_xfer) begin
          ctrl.shift = 1'b1;
          if (m_tlast) begin
            state_next   = isrt_pkg::ST_FILL;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = isrt_pkg::ST_FILL;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [isrt_pkg::VALUE_W-1:0] left_value;
    logic                                left_valid;
    logic                                left_gt;
    logic signed [isrt_pkg::VALUE_W-1:0] right_value;
    logic                                right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ins_value   (ins_value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // occupied cells always form a contiguous run from the head
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("occupied cells not contiguous");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cell_valid[0])
    else $error("result offered from an empty chain");

  a_close_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tlast) |=> (m_tvalid && !s_tready))
    else $error("closing transfer did not start the drain");

  a_final_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (s_tready && !m_tuser && !cell_valid[0]))
    else $error("chain not emptied after final result");

endmodule
